// ----- rtl/fdfw_pkg.sv -----
// ----------------------------------------------------------------------------
// fdfw_pkg
// shared types and constants of the fragment depth and fog writer
// ----------------------------------------------------------------------------
package fdfw_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_TEST,
    ST_FOG,
    ST_BLEND,
    ST_PACK
  } fdfw_state_e;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TEST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_ENABLE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_LINEAR  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_START   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_INV     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_COLOR   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 4'd7;

  localparam logic [1:0] STATUS_WRITTEN = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_DEPTH   = 2'd2;

  localparam logic [31:0] DEPTH_FAR = 32'h7FFF_FFFF;
  localparam logic [9:0]  AREA_SIDE_RESET = 10'd512;
  localparam logic [16:0] FACTOR_ONE = 17'h1_0000;

  localparam int unsigned IDX_W = 25;
  localparam int unsigned PROD_W = 65;

  typedef struct packed {
    logic load;
    logic fog_on;
  } fdfw_color_ctl_t;

endpackage

// ----- rtl/fdfw_color.sv -----
// ----------------------------------------------------------------------------
// fdfw_color
// fog factor clamp, linear blend of three channels and 8-bit scaling
// ----------------------------------------------------------------------------
module fdfw_color
  import fdfw_pkg::*;
(
  input  logic                         clk_i,
  input  fdfw_color_ctl_t              ctl_i,
  input  logic signed [PROD_W-1:0]     fog_prod_i,
  input  logic        [2:0][15:0]      color_i,
  input  logic        [2:0][15:0]      fog_color_i,
  output logic        [2:0][7:0]       byte_o
);

  logic        [16:0] factor;
  logic        [16:0] factor_inv;
  logic signed [33:0] factor_ext;
  logic signed [33:0] factor_inv_ext;
  logic signed [33:0] blend_d [3];
  logic signed [33:0] blend_q [3];
  logic        [30:0] clamped [3];
  logic        [38:0] scaled  [3];

  // factor in Q1.16, clamped to [0, 1]
  always_comb begin
    if (!ctl_i.fog_on || fog_prod_i[PROD_W-1] || fog_prod_i == '0) begin
      factor = '0;
    end else if (|fog_prod_i[PROD_W-2:40]) begin
      factor = FACTOR_ONE;
    end else begin
      factor = {1'b0, fog_prod_i[39:24]};
    end
    factor_inv     = FACTOR_ONE - factor;
    factor_ext     = $signed(34'(factor));
    factor_inv_ext = $signed(34'(factor_inv));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blend_d[k] = 34'($signed(color_i[k])) * factor_inv_ext
                 + 34'($signed(fog_color_i[k])) * factor_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int k = 0; k < 3; k++) begin
        blend_q[k] <= blend_d[k];
      end
    end
  end

  // clamp to [0, 1.0] in Q2.30 and scale by 255
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (blend_q[k][33]) begin
        clamped[k] = '0;
      end else if (blend_q[k][32:0] > 33'h4000_0000) begin
        clamped[k] = 31'h4000_0000;
      end else begin
        clamped[k] = blend_q[k][30:0];
      end
      scaled[k] = {clamped[k], 8'd0} - {8'd0, clamped[k]};
      byte_o[k] = scaled[k][37:30];
    end
  end

endmodule

// ----- rtl/fragment_depth_fog_writer.sv -----
// ----------------------------------------------------------------------------
// fragment_depth_fog_writer
// per-fragment bounds check, depth test against a depth memory, linear fog
// ----------------------------------------------------------------------------
// Fragments enter on the in channel (valid/ready) and each one produces one
// word on the out channel: a status, the framebuffer index and an 8-bit color.
// The config channel writes one register per word; write only while idle.
// Depth lives in a single-port synchronous memory of PIXELS entries. An item
// walks address, depth read/test/write-back, fog multiply, blend and pack; a
// rejected one skips fog and blend. A new fragment is taken only once the
// last one has left pack; the depth read-modify-write uses the one port.
// out_valid_o is registered and rises once pack loads the output register.
// Results wait in an output register: when the receiver stalls, the next
// fragment is still taken and worked on up to the pack step, where it holds
// until the output register frees.
// After reset the block sweeps all PIXELS depth entries to the farthest depth,
// one entry a cycle with in_ready_o low; config writes are taken.
// ----------------------------------------------------------------------------
module fragment_depth_fog_writer
  import fdfw_pkg::*;
#(
  parameter int unsigned PIXELS = 262144
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [12:0]      pixel_x_i,
  input  logic signed [12:0]      pixel_y_i,
  input  logic signed [31:0]      frag_depth_i,
  input  logic signed [15:0]      red_in_i,
  input  logic signed [15:0]      green_in_i,
  input  logic signed [15:0]      blue_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [17:0]             pixel_index_o,
  output logic [7:0]              red_out_o,
  output logic [7:0]              green_out_o,
  output logic [7:0]              blue_out_o
);

  localparam int unsigned AW = $clog2(PIXELS);
  localparam logic [AW-1:0] CLR_LAST = AW'(PIXELS - 1);
  localparam logic [IDX_W-2:0] PIX_LIMIT = (IDX_W-1)'(PIXELS);

  fdfw_state_e state_q, state_d;

  // config registers
  logic               depth_test_q;
  logic               fog_enable_q;
  logic               fog_linear_q;
  logic signed [31:0] fog_start_q;
  logic signed [31:0] fog_inv_q;
  logic [47:0]        fog_color_q;
  logic [9:0]         area_width_q;
  logic [9:0]         area_height_q;

  // item registers
  logic signed [12:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [2:0][15:0]   color_q;
  logic [AW-1:0]      addr_q;
  logic [17:0]        index_q;
  logic [1:0]         status_q;
  logic               range_fail_q;
  logic               fog_on_q;
  logic [31:0]        fog_diff_q;
  logic signed [PROD_W-1:0] fog_prod_q;

  // depth memory
  logic [31:0]   depth_mem [PIXELS];
  logic [31:0]   rd_data_q;
  logic [AW-1:0] clr_q;
  logic          mem_rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [17:0] out_index_q;
  logic [2:0][7:0] out_color_q;

  logic signed [IDX_W-1:0] idx;
  logic [19:0]             area;
  logic                    range_fail;
  logic                    depth_fail;
  logic                    fog_on;
  logic signed [32:0]      fog_diff;
  logic                    out_free;
  logic                    in_accept;
  fdfw_color_ctl_t         color_ctl;
  logic [2:0][7:0]         color_byte;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_test_q  <= 1'b0;
      fog_enable_q  <= 1'b0;
      fog_linear_q  <= 1'b0;
      fog_start_q   <= '0;
      fog_inv_q     <= '0;
      fog_color_q   <= '0;
      area_width_q  <= AREA_SIDE_RESET;
      area_height_q <= AREA_SIDE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEPTH_TEST:  depth_test_q  <= cfg_data_i[0];
        REG_FOG_ENABLE:  fog_enable_q  <= cfg_data_i[0];
        REG_FOG_LINEAR:  fog_linear_q  <= cfg_data_i[0];
        REG_FOG_START:   fog_start_q   <= cfg_data_i[31:0];
        REG_FOG_INV:     fog_inv_q     <= cfg_data_i[31:0];
        REG_FOG_COLOR:   fog_color_q   <= cfg_data_i[47:0];
        REG_AREA_WIDTH:  area_width_q  <= cfg_data_i[9:0];
        REG_AREA_HEIGHT: area_height_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // index and bounds
  always_comb begin
    idx  = IDX_W'(x_q) + IDX_W'(y_q) * IDX_W'($signed({1'b0, area_width_q}));
    area = 20'(area_width_q) * 20'(area_height_q);
    range_fail = idx[IDX_W-1]
              || (idx[IDX_W-2:0] >= (IDX_W-1)'(area))
              || (idx[IDX_W-2:0] >= PIX_LIMIT);
  end

  always_comb begin
    depth_fail = depth_test_q && (z_q >= $signed(rd_data_q));
    fog_on     = fog_enable_q && fog_linear_q && (z_q > fog_start_q);
    fog_diff   = 33'(z_q) - 33'(fog_start_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_TEST;
      ST_TEST:  state_d = (range_fail_q || depth_fail) ? ST_PACK : ST_FOG;
      ST_FOG:   state_d = ST_BLEND;
      ST_BLEND: state_d = ST_PACK;
      ST_PACK:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    mem_rd_en  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = z_q;
    color_ctl  = '{load: 1'b0, fog_on: fog_on_q};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = DEPTH_FAR;
      end
      ST_IDLE:  in_ready_o = 1'b1;
      ST_ADDR:  mem_rd_en = 1'b1;
      ST_TEST:  mem_we = !range_fail_q && !depth_fail;
      ST_BLEND: color_ctl.load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      rd_data_q <= depth_mem[idx[AW-1:0]];
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      z_q     <= frag_depth_i;
      color_q <= {red_in_i, green_in_i, blue_in_i};
    end
    if (state_q == ST_ADDR) begin
      addr_q       <= idx[AW-1:0];
      range_fail_q <= range_fail;
      index_q      <= range_fail ? 18'd0 : idx[17:0];
      status_q     <= range_fail ? STATUS_RANGE : STATUS_WRITTEN;
    end
    if (state_q == ST_TEST) begin
      if (!range_fail_q && depth_fail) begin
        status_q <= STATUS_DEPTH;
      end
      fog_on_q   <= fog_on;
      fog_diff_q <= fog_diff[31:0];
    end
    if (state_q == ST_FOG) begin
      fog_prod_q <= $signed({1'b0, fog_diff_q}) * fog_inv_q;
    end
  end

  fdfw_color u_color (
    .clk_i       (clk_i),
    .ctl_i       (color_ctl),
    .fog_prod_i  (fog_prod_q),
    .color_i     (color_q),
    .fog_color_i (fog_color_q),
    .byte_o      (color_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_PACK && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PACK && out_free) begin
      out_status_q <= status_q;
      out_index_q  <= index_q;
      out_color_q  <= (status_q == STATUS_WRITTEN) ? color_byte : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign pixel_index_o = out_index_q;
  assign red_out_o     = out_color_q[2];
  assign green_out_o   = out_color_q[1];
  assign blue_out_o    = out_color_q[0];

  // depth memory only takes fragments that passed both checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && state_q != ST_CLEAR |-> !range_fail_q && !depth_fail)
    else $error("depth write for a rejected fragment");

  // rejected words carry no color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_WRITTEN |->
      red_out_o == 8'd0 && green_out_o == 8'd0 && blue_out_o == 8'd0)
    else $error("rejected fragment with nonzero color");

  // out of range words carry index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_RANGE |-> pixel_index_o == 18'd0)
    else $error("out of range fragment with nonzero index");

  // an accepted fragment always goes to address generation next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_ADDR)
    else $error("accepted fragment lost by the sequencer");

endmodule

// ----- dv/fragment_depth_fog_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fragment_depth_fog_writer_tb
// self-checking bench for the fragment depth test and linear fog writer
// ----------------------------------------------------------------------------
// Fragments go in on the in channel with random gaps, registers on the config
// channel without gaps, both valid/ready. Out is drained with random stalls.
// Every accepted fragment runs through a local model of the bounds check,
// depth test, fog blend and 8-bit conversion with its own copy of the depth
// memory, and the expected word is queued. Each word out of the block is
// compared field by field with the oldest queued word. A short directed table,
// with a few words typed in by hand, comes first; then random phases, each
// with its own register setting, reusing a small pixel window so that depth
// tests both pass and fail. Registers change only once the block is idle.
// ----------------------------------------------------------------------------
module fragment_depth_fog_writer_tb;
  import fdfw_pkg::*;

  localparam int unsigned PIXELS = 262144;
  localparam int unsigned PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 1200000;
  localparam int unsigned MAX_REPORTS = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

  typedef enum int {
    GAPS_NONE,
    GAPS_FULL,
    GAPS_MIXED
  } gap_mode_e;

  typedef struct {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic signed [31:0] depth;
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
  } frag_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] pix_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } frag_word_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    frag_t                 frag;
    bit                    typed;
    frag_word_t            word;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic signed [12:0] pixel_x = '0;
  logic signed [12:0] pixel_y = '0;
  logic signed [31:0] frag_depth = '0;
  logic signed [15:0] red_in = '0;
  logic signed [15:0] green_in = '0;
  logic signed [15:0] blue_in = '0;
  logic out_ready = 1'b0;

  logic cfg_ready_o;
  logic in_ready_o;
  logic out_valid_o;
  logic [1:0] status_o;
  logic [17:0] pixel_index_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;

  // register shadow, reset values
  logic cfg_depth_test = 1'b0;
  logic cfg_fog_on = 1'b0;
  logic cfg_fog_linear = 1'b0;
  logic signed [31:0] cfg_fog_start = '0;
  logic signed [31:0] cfg_fog_inv = '0;
  logic [47:0] cfg_fog_color = '0;
  logic [9:0] cfg_width = AREA_SIDE_RESET;
  logic [9:0] cfg_height = AREA_SIDE_RESET;

  logic [31:0] depth_shadow [PIXELS];
  frag_word_t pending_words [$];
  stim_row_t plan [$];
  gap_mode_e in_gap_mode = GAPS_FULL;
  gap_mode_e out_gap_mode = GAPS_FULL;
  int mismatches = 0;
  int cycle_count = 0;

  fragment_depth_fog_writer #(
    .PIXELS(PIXELS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .frag_depth_i (frag_depth),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .status_o     (status_o),
    .pixel_index_o(pixel_index_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL fragment_depth_fog_writer");
      $finish;
    end
  end

  function automatic int draw_gap(input gap_mode_e mode);
    case (mode)
      GAPS_NONE: return 0;
      GAPS_FULL: return $urandom_range(0, 14);
      default:   return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 14);
    endcase
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DEPTH_TEST:  cfg_depth_test = data[0];
      REG_FOG_ENABLE:  cfg_fog_on = data[0];
      REG_FOG_LINEAR:  cfg_fog_linear = data[0];
      REG_FOG_START:   cfg_fog_start = data[31:0];
      REG_FOG_INV:     cfg_fog_inv = data[31:0];
      REG_FOG_COLOR:   cfg_fog_color = data[47:0];
      REG_AREA_WIDTH:  cfg_width = data[9:0];
      REG_AREA_HEIGHT: cfg_height = data[9:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] to_byte(input longint v);
    longint c;
    c = (v < 0) ? 0 : (v > (longint'(1) << 30)) ? (longint'(1) << 30) : v;
    return 8'((c * 255) >>> 30);
  endfunction

  // bounds check, depth test, fog blend; updates the depth shadow on a write
  function automatic frag_word_t shade_fragment(input frag_t f);
    frag_word_t w;
    longint idx, total, z, d, p, fac;
    longint col [3];
    longint fog [3];
    longint chan [3];
    w = '0;
    idx = longint'(f.x) + longint'(f.y) * longint'(cfg_width);
    total = longint'(cfg_width) * longint'(cfg_height);
    if (total > longint'(PIXELS)) total = longint'(PIXELS);
    if (idx < 0 || idx >= total) begin
      w.status = STATUS_RANGE;
      return w;
    end
    w.pix_index = idx[17:0];
    z = longint'(f.depth);
    if (cfg_depth_test && z >= longint'($signed(depth_shadow[idx]))) begin
      w.status = STATUS_DEPTH;
      return w;
    end
    col[0] = longint'(f.red);
    col[1] = longint'(f.green);
    col[2] = longint'(f.blue);
    fog[0] = longint'($signed(cfg_fog_color[47:32]));
    fog[1] = longint'($signed(cfg_fog_color[31:16]));
    fog[2] = longint'($signed(cfg_fog_color[15:0]));
    fac = 0;
    if (cfg_fog_on && cfg_fog_linear && z > longint'(cfg_fog_start)) begin
      d = z - longint'(cfg_fog_start);
      p = d * longint'(cfg_fog_inv);
      if (p <= 0) fac = 0;
      else if (p >= (longint'(1) << 40)) fac = 65536;
      else fac = p >>> 24;
    end
    for (int k = 0; k < 3; k++) begin
      chan[k] = col[k] * (65536 - fac) + fog[k] * fac;
    end
    depth_shadow[idx] = f.depth;
    w.status = STATUS_WRITTEN;
    w.red = to_byte(chan[0]);
    w.green = to_byte(chan[1]);
    w.blue = to_byte(chan[2]);
    return w;
  endfunction

  function automatic stim_row_t frag_row(input int x, y, input logic [31:0] z,
                                         input int r, g, b);
    stim_row_t row;
    row.is_reg = 1'b0;
    row.reg_idx = '0;
    row.reg_data = '0;
    row.typed = 1'b0;
    row.word = '0;
    row.frag.x = 13'(x);
    row.frag.y = 13'(y);
    row.frag.depth = z;
    row.frag.red = 16'(r);
    row.frag.green = 16'(g);
    row.frag.blue = 16'(b);
    return row;
  endfunction

  function automatic void add_frag(input int x, y, input logic [31:0] z, input int r, g, b);
    plan.push_back(frag_row(x, y, z, r, g, b));
  endfunction

  function automatic void add_checked(input int x, y, input logic [31:0] z,
                                      input int r, g, b, input logic [1:0] st,
                                      input int pix, ro, go, bo);
    stim_row_t row;
    row = frag_row(x, y, z, r, g, b);
    row.typed = 1'b1;
    row.word.status = st;
    row.word.pix_index = 18'(pix);
    row.word.red = 8'(ro);
    row.word.green = 8'(go);
    row.word.blue = 8'(bo);
    plan.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = frag_row(0, 0, '0, 0, 0, 0);
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    plan.push_back(row);
  endfunction

  function automatic logic [15:0] rand_channel();
    return ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 16384)) : 16'($urandom);
  endfunction

  function automatic logic [9:0] pick_side();
    case ($urandom_range(0, 4))
      0: return 10'd1;
      1: return 10'd512;
      2: return 10'd1023;
      default: return 10'($urandom_range(2, 40));
    endcase
  endfunction

  // mostly in-area fragments, many in a small window to revisit depths
  function automatic frag_t make_fragment();
    frag_t f;
    int sel, wx, hy;
    sel = $urandom_range(0, 9);
    if (sel < 8 && cfg_width != 0 && cfg_height != 0) begin
      if (sel < 5) begin
        wx = (cfg_width < 24) ? int'(cfg_width) : 24;
        hy = (cfg_height < 24) ? int'(cfg_height) : 24;
      end else begin
        wx = int'(cfg_width);
        hy = int'(cfg_height);
      end
      f.x = 13'($urandom_range(0, wx - 1));
      f.y = 13'($urandom_range(0, hy - 1));
    end else begin
      f.x = 13'($urandom);
      f.y = 13'($urandom);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: f.depth = cfg_fog_start + 32'($urandom_range(0, 1 << 20));
      4, 5, 6:    f.depth = 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      default:    f.depth = $urandom;
    endcase
    f.red = rand_channel();
    f.green = rand_channel();
    f.blue = rand_channel();
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[cycle %0d] mismatch: %s", cycle_count, what);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    apply_register(idx, data);
  endtask

  task automatic send_fragment(input frag_t f, input bit typed, input frag_word_t typed_word);
    int gap;
    frag_word_t predicted;
    gap = draw_gap(in_gap_mode);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_x <= f.x;
    pixel_y <= f.y;
    frag_depth <= f.depth;
    red_in <= f.red;
    green_in <= f.green;
    blue_in <= f.blue;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    predicted = shade_fragment(f);
    pending_words.push_back(typed ? typed_word : predicted);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_phase(input int p);
    logic [9:0] w, h;
    logic [31:0] start, inv;
    logic de, fog_on, linear;
    fog_on = (p == 0 || p == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
    linear = (p == 0 || p == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
    case (p)
      0: begin
        w = 10'd1023;
        h = 10'd1023;
        start = 32'h8000_0000;
        inv = 32'h7FFF_FFFF;
        de = 1'b1;
      end
      1: begin
        w = 10'd1;
        h = 10'd1;
        start = 32'h7FFF_FFFF;
        inv = 32'h8000_0000;
        de = 1'b0;
      end
      2: begin
        w = 10'd512;
        h = 10'd512;
        start = '0;
        inv = 32'h0001_0000;
        de = 1'b1;
      end
      default: begin
        w = pick_side();
        h = pick_side();
        start = ($urandom_range(0, 1) != 0) ? $urandom
                                           : 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
        inv = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> $urandom_range(8, 16));
        de = 1'($urandom_range(0, 1));
      end
    endcase
    write_register(REG_DEPTH_TEST, {47'($urandom), de});
    write_register(REG_FOG_ENABLE, {47'($urandom), fog_on});
    write_register(REG_FOG_LINEAR, {47'($urandom), linear});
    write_register(REG_FOG_START, {16'($urandom), start});
    write_register(REG_FOG_INV, {16'($urandom), inv});
    write_register(REG_FOG_COLOR, {rand_channel(), rand_channel(), rand_channel()});
    write_register(REG_AREA_WIDTH, {32'($urandom), 6'($urandom), w});
    write_register(REG_AREA_HEIGHT, {32'($urandom), 6'($urandom), h});
  endtask

  initial begin : result_monitor
    int stall;
    frag_word_t got, want;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(out_gap_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid_o && out_ready));
      got.status = status_o;
      got.pix_index = pixel_index_o;
      got.red = red_out_o;
      got.green = green_out_o;
      got.blue = blue_out_o;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, status %0d index %0d",
                                  got.status, got.pix_index));
      end else begin
        want = pending_words.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.pix_index !== want.pix_index)
          report_mismatch($sformatf("index %0d, expected %0d", got.pix_index, want.pix_index));
        if (got.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d at index %0d",
                                    got.red, want.red, want.pix_index));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d at index %0d",
                                    got.green, want.green, want.pix_index));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d at index %0d",
                                    got.blue, want.blue, want.pix_index));
      end
    end
  end

  initial begin : stimulus
    bit prev_reg;
    for (int i = 0; i < PIXELS; i++) depth_shadow[i] = DEPTH_FAR;

    // reset settings: 512 x 512, no depth test, no fog
    add_checked(0, 0, 32'd0, 16384, 0, -1, STATUS_WRITTEN, 0, 255, 0, 0);
    add_checked(-1, 0, 32'd0, 100, 100, 100, STATUS_RANGE, 0, 0, 0, 0);
    add_checked(511, 511, 32'h7FFF_FFFF, 32767, -32768, 8192,
                STATUS_WRITTEN, 262143, 255, 0, 127);
    add_checked(0, 512, 32'd0, 1, 1, 1, STATUS_RANGE, 0, 0, 0, 0);
    add_checked(4095, 4095, 32'd0, 1, 1, 1, STATUS_RANGE, 0, 0, 0, 0);
    add_checked(-4096, -4096, 32'd0, 1, 1, 1, STATUS_RANGE, 0, 0, 0, 0);
    add_checked(-4096, 8, 32'd5, 1, 2, 3, STATUS_WRITTEN, 0, 0, 0, 0);
    // depth test
    add_reg(REG_DEPTH_TEST, 48'd1);
    add_checked(0, 0, 32'd5, 16384, 16384, 16384, STATUS_DEPTH, 0, 0, 0, 0);
    add_frag(0, 0, 32'd4, 16384, 8192, 4096);
    add_checked(100, 1, 32'h7FFF_FFFF, 1, 1, 1, STATUS_DEPTH, 612, 0, 0, 0);
    add_frag(100, 1, 32'h8000_0000, -5, 20000, 12345);
    // fog on but not linear
    add_reg(REG_FOG_ENABLE, 48'd1);
    add_frag(5, 5, 32'd1000, 8000, 16000, -300);
    // linear fog from 1.0 with span 2.0
    add_reg(REG_FOG_LINEAR, 48'd1);
    add_reg(REG_FOG_START, 48'h0000_0001_0000);
    add_reg(REG_FOG_INV, 48'h0000_0080_0000);
    add_reg(REG_FOG_COLOR, 48'h4000_0000_2000);
    add_frag(6, 6, 32'h0001_0000, 4000, 8000, 12000);
    add_frag(6, 7, 32'h0002_0000, 4000, 8000, 12000);
    add_checked(7, 7, 32'h7FFF_0000, 0, 16384, -200, STATUS_WRITTEN, 3591, 255, 0, 127);
    // negative factor clamps to no fog
    add_reg(REG_FOG_INV, 48'h0000_8000_0000);
    add_checked(8, 8, 32'h0005_0000, 16384, 16384, 16384,
                STATUS_WRITTEN, 4104, 255, 255, 255);
    // area larger than the depth memory
    add_reg(REG_AREA_WIDTH, 48'd1023);
    add_reg(REG_AREA_HEIGHT, 48'd1023);
    add_frag(0, 256, 32'd0, 300, 600, 900);
    add_checked(1000, 256, 32'd0, 1, 1, 1, STATUS_RANGE, 0, 0, 0, 0);
    // empty area
    add_reg(REG_AREA_WIDTH, 48'd0);
    add_checked(0, 0, 32'd0, 1, 1, 1, STATUS_RANGE, 0, 0, 0, 0);
    add_reg(REG_AREA_WIDTH, 48'd1);
    add_reg(REG_AREA_HEIGHT, 48'd1);
    add_frag(0, 0, 32'd3, 16384, 0, 16384);
    add_checked(1, 0, 32'd3, 1, 1, 1, STATUS_RANGE, 0, 0, 0, 0);
    // write to an unused register index is dropped
    add_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    add_frag(0, 0, 32'd2, -1, 32767, 5000);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) quiesce();
        write_register(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_fragment(plan[i].frag, plan[i].typed, plan[i].word);
      end
      prev_reg = plan[i].is_reg;
    end

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      configure_phase(p);
      in_gap_mode = gap_mode_e'(p % 3);
      out_gap_mode = gap_mode_e'((p + 1) % 3);
      repeat (ITEMS_PER_PHASE) send_fragment(make_fragment(), 1'b0, '0);
    end

    quiesce();
    if (mismatches == 0) begin
      $display("PASS fragment_depth_fog_writer");
    end else begin
      $display("FAIL fragment_depth_fog_writer");
    end
    $finish;
  end

endmodule
